### hdl/base32_checked_decoder_defines.svh
// Assertion macros for the base32 checked decoder.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BASE32_CHECKED_DECODER_DEFINES_SVH
`define BASE32_CHECKED_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BCD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("base32 decoder: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("base32 decoder: next-cycle check failed");

`endif

### hdl/bcd_pkg.sv
// Shared types and constants for the base32 checked decoder.
// No dependencies.
package bcd_pkg;

    localparam int ACC_W     = 40;
    localparam int JOB_DEPTH = 4;

    typedef enum logic [0:0] {
        CFG_ALPHABET_HEX      = 1'b0,
        CFG_ALLOW_MISSING_PAD = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } t_kind;

    // Work handed from the front to the back: bytes to emit, and a status if it ends a text.
    typedef struct packed {
        logic [ACC_W-1:0] data;
        logic [2:0]       nbytes;
        logic             is_end;
        logic             ok;
    } t_job;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_status;
        logic       text_ok;
        logic       last;
    } t_result;

endpackage

### hdl/bcd_front.sv
// Front end of the base32 checked decoder: configuration, character
// classification, group assembly and end check. Depends on bcd_pkg.
module bcd_front import bcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    input  logic       i_accept,
    input  logic       i_kind,
    input  logic [7:0] i_symbol,
    output logic       o_job_push,
    output t_job       o_job
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_Z     = 8'h5a;

    typedef enum logic [1:0] {
        CLS_SYM,
        CLS_SPACE,
        CLS_PAD,
        CLS_BAD
    } t_cls_kind;

    typedef struct packed {
        t_cls_kind  cls;
        logic [4:0] val;
    } t_class;

    function automatic t_class classify(input logic [7:0] c, input logic hex);
        t_class r;
        r.cls = CLS_BAD;
        r.val = '0;
        if (c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE) begin
            r.cls = CLS_SPACE;
        end else if (c == CH_EQ) begin
            r.cls = CLS_PAD;
        end else if (hex) begin
            if (c >= CH_0 && c <= CH_9) begin
                r.cls = CLS_SYM;
                r.val = 5'(c - CH_0);
            end else if (c >= CH_A && c <= CH_V) begin
                r.cls = CLS_SYM;
                r.val = 5'(c - CH_A + 8'd10);
            end
        end else begin
            if (c >= CH_A && c <= CH_Z) begin
                r.cls = CLS_SYM;
                r.val = 5'(c - CH_A);
            end else if (c >= CH_2 && c <= CH_7) begin
                r.cls = CLS_SYM;
                r.val = 5'(c - CH_2 + 8'd26);
            end
        end
        return r;
    endfunction

    logic             r_alpha_hex, r_allow_missing;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [2:0]       r_cnt, n_cnt;
    logic             r_pad_phase, n_pad_phase;
    logic [2:0]       r_pcnt, n_pcnt;
    logic             r_err, n_err;

    t_class           w_cls;
    logic [5:0]       w_shift;
    logic [ACC_W-1:0] w_acc_sym;
    logic [3:0]       w_k;
    logic [3:0]       w_sum;
    logic             w_bad_len;
    logic             w_need_pad;
    logic             w_end_ok;
    logic [2:0]       w_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_hex     <= 1'b0;
            r_allow_missing <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHABET_HEX:      r_alpha_hex     <= i_cfg_data;
                CFG_ALLOW_MISSING_PAD: r_allow_missing <= i_cfg_data;
            endcase
        end
    end

    // First symbol of a group lands in the top five bits.
    assign w_cls     = classify(i_symbol, r_alpha_hex);
    assign w_shift   = 6'(3'd7 - r_cnt) * 6'd5;
    assign w_acc_sym = r_acc | (ACC_W'(w_cls.val) << w_shift);

    // End check; a leftover count of zero stands for a full group of eight.
    assign w_k        = (r_cnt == 3'd0) ? 4'd8 : {1'b0, r_cnt};
    assign w_sum      = w_k + {1'b0, r_pcnt};
    assign w_bad_len  = (w_k == 4'd1) || (w_k == 4'd3) || (w_k == 4'd6);
    assign w_need_pad = !r_allow_missing || (r_pcnt != 3'd0);
    assign w_end_ok   = !r_err && !w_bad_len && (r_pcnt != 3'd7)
                        && !(w_need_pad && (w_sum != 4'd8));

    always_comb begin
        case (r_cnt)
            3'd2:    w_tail = 3'd1;
            3'd4:    w_tail = 3'd2;
            3'd5:    w_tail = 3'd3;
            3'd7:    w_tail = 3'd4;
            default: w_tail = 3'd0;
        endcase
    end

    always_comb begin
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_pad_phase = r_pad_phase;
        n_pcnt      = r_pcnt;
        n_err       = r_err;
        o_job_push  = 1'b0;
        o_job       = '{data: r_acc, nbytes: 3'd0, is_end: 1'b0, ok: 1'b0};
        if (i_accept) begin
            if (t_kind'(i_kind) == KIND_END) begin
                o_job_push  = 1'b1;
                o_job.is_end = 1'b1;
                o_job.ok     = w_end_ok;
                o_job.nbytes = w_end_ok ? w_tail : 3'd0;
                n_acc       = '0;
                n_cnt       = '0;
                n_pad_phase = 1'b0;
                n_pcnt      = '0;
                n_err       = 1'b0;
            end else if (r_pad_phase) begin
                // Count '=' only, saturating; drop everything else.
                if (w_cls.cls == CLS_PAD && r_pcnt != 3'd7) begin
                    n_pcnt = r_pcnt + 3'd1;
                end
            end else begin
                unique case (w_cls.cls)
                    CLS_PAD: begin
                        n_pad_phase = 1'b1;
                        n_pcnt      = 3'd1;
                    end
                    CLS_BAD: begin
                        n_err = 1'b1;
                    end
                    CLS_SPACE: begin
                    end
                    CLS_SYM: begin
                        if (r_cnt == 3'd7) begin
                            o_job_push   = 1'b1;
                            o_job.data   = w_acc_sym;
                            o_job.nbytes = 3'd5;
                            n_acc        = '0;
                            n_cnt        = '0;
                        end else begin
                            n_acc = w_acc_sym;
                            n_cnt = r_cnt + 3'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_pad_phase <= 1'b0;
            r_pcnt      <= '0;
            r_err       <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_pad_phase <= n_pad_phase;
            r_pcnt      <= n_pcnt;
            r_err       <= n_err;
        end
    end

endmodule

### hdl/bcd_job_fifo.sv
// Short job queue between the front and back of the base32 checked decoder.
// Depends on bcd_pkg for the job type.
module bcd_job_fifo import bcd_pkg::*; #(
    parameter int DEPTH = JOB_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

### hdl/bcd_back.sv
// Back end of the base32 checked decoder: walks each job one beat at a time
// into the result register. Depends on bcd_pkg.
module bcd_back import bcd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic       r_out_valid, n_out_valid;
    t_result    r_out;
    logic [2:0] r_idx, n_idx;
    logic       w_load;
    logic [7:0] w_byte;
    t_result    w_res;

    always_comb begin
        case (r_idx)
            3'd0:    w_byte = i_job.data[ACC_W-1  -: 8];
            3'd1:    w_byte = i_job.data[ACC_W-9  -: 8];
            3'd2:    w_byte = i_job.data[ACC_W-17 -: 8];
            3'd3:    w_byte = i_job.data[ACC_W-25 -: 8];
            3'd4:    w_byte = i_job.data[ACC_W-33 -: 8];
            default: w_byte = '0;
        endcase
    end

    // Data bytes first, then the status beat on an end job.
    always_comb begin
        if (r_idx < i_job.nbytes) begin
            w_res.data_byte = w_byte;
            w_res.is_status = 1'b0;
            w_res.text_ok   = 1'b0;
            w_res.last      = !i_job.is_end && (r_idx == i_job.nbytes - 3'd1);
        end else begin
            w_res.data_byte = '0;
            w_res.is_status = 1'b1;
            w_res.text_ok   = i_job.ok;
            w_res.last      = 1'b1;
        end
    end

    assign w_load    = i_job_valid && (!r_out_valid || i_pop);
    assign o_job_pop = w_load && w_res.last;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_idx       = w_res.last ? 3'd0 : r_idx + 3'd1;
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

### hdl/base32_checked_decoder.sv
// Base32 checked decoder (standard or extended-hex alphabet), streaming.
// Input queue: push/full carries one beat per character (i_kind = 0) or an
//   end-of-text beat (i_kind = 1); a beat is taken when push is high and
//   full is low. One beat can be taken every cycle.
// Result queue: empty/pop; the oldest result sits on o_data_byte, o_is_status,
//   o_text_ok and o_last while empty is low and leaves when pop is high.
// Every eighth symbol yields five bytes; an end beat yields 0 to 4 tail bytes
//   and then a status beat. Bytes stream out before the status, so drop a
//   text's bytes when its status has o_text_ok low. o_last marks the final
//   result caused by one input beat.
// Path: with an idle back end, the job that a beat causes is written into the
//   job queue, then loaded into the result register, then shown on the ports.
// Throughput: one input beat per cycle while full is low; one result per cycle
//   while pop is high, from a single result register. Jobs wait in a DEPTH-entry
//   queue between the classifier and the byte sequencer; full rises when the
//   queue fills, only when the result side drains slower than jobs arrive.
// Reset (i_rst_n low, synchronous) clears the decode state, empties the queue and
//   the result register and clears both configuration registers. Write configuration
//   through i_cfg_we/i_cfg_idx/i_cfg_data only while no text is in flight.
// A stalled receiver holds the current result; the queue absorbs new jobs.
`include "base32_checked_decoder_defines.svh"

module base32_checked_decoder import bcd_pkg::*; #(
    parameter int DEPTH = JOB_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic       i_kind,
    input  logic [7:0] i_symbol,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_byte,
    output logic       o_is_status,
    output logic       o_text_ok,
    output logic       o_last
);

    logic    w_accept;
    logic    w_job_push;
    t_job    w_job_in;
    logic    w_job_valid;
    logic    w_job_pop;
    t_job    w_head;
    t_result w_result;

    assign w_accept = push && !full;

    bcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_kind     (i_kind),
        .i_symbol   (i_symbol),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    bcd_job_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .i_pop   (w_job_pop),
        .o_full  (full),
        .o_valid (w_job_valid),
        .o_head  (w_head)
    );

    bcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_head),
        .o_job_pop   (w_job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (w_result)
    );

    assign o_data_byte = w_result.data_byte;
    assign o_is_status = w_result.is_status;
    assign o_text_ok   = w_result.text_ok;
    assign o_last      = w_result.last;

    `BCD_ASSERT_IMPLY(a_status_is_last, !empty && o_is_status, o_last && (o_data_byte == 8'd0))
    `BCD_ASSERT_IMPLY(a_ok_only_in_status, !empty && !o_is_status, !o_text_ok)
    `BCD_ASSERT_NEXT(a_group_ends_on_last, w_job_pop && !w_head.is_end, !empty && o_last && !o_is_status)

endmodule
